/* design/tfp_pkg.sv */
// ----------------------------------------------------------------------------
// tfp_pkg
// Shared types, constants and table functions for the prescaler selector.
// ----------------------------------------------------------------------------
package tfp_pkg;

    // Default core clock in Hz
    localparam int unsigned CLOCK_HZ_DEFAULT = 32'd16000000;

    // Depth of the job queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // Prescaler table size and largest usable compare count
    localparam int unsigned PRESC_COUNT   = 7;
    localparam int unsigned COMPARE_LIMIT = 255;

    // Output pin mode codes
    localparam logic [1:0] PIN_UNCHANGED = 2'd0;
    localparam logic [1:0] PIN_OFF       = 2'd1;
    localparam logic [1:0] PIN_TOGGLE    = 2'd2;

    typedef struct packed {
        logic [15:0] frequency;
        logic        update_pin_mode;
    } t_req;

    typedef struct packed {
        logic       fit_found;
        logic [2:0] clock_select;
        logic [7:0] compare_value;
        logic [1:0] pin_mode;
    } t_result;

    // Classified request as it travels from front to back
    typedef struct packed {
        logic [15:0] divisor;
        logic [1:0]  pin_mode;
        logic        off;
    } t_job;

    // Prescalers are 1, 8, 32, 64, 128, 256, 1024: all powers of two
    function automatic logic [3:0] presc_shift(input logic [2:0] idx);
        logic [3:0] sh;
        case (idx)
            3'd0:    sh = 4'd0;
            3'd1:    sh = 4'd3;
            3'd2:    sh = 4'd5;
            3'd3:    sh = 4'd6;
            3'd4:    sh = 4'd7;
            3'd5:    sh = 4'd8;
            3'd6:    sh = 4'd10;
            default: sh = 4'd0;
        endcase
        return sh;
    endfunction

    // Exclusive upper bound of ticks for a prescaler: 255 * prescaler
    function automatic logic [31:0] presc_limit(input logic [2:0] idx);
        return 32'(COMPARE_LIMIT) << presc_shift(idx);
    endfunction

endpackage

/* design/tfp_front.sv */
// ----------------------------------------------------------------------------
// tfp_front
// Request classification: off requests, zero frequency and pin mode.
// ----------------------------------------------------------------------------
module tfp_front (
    input  logic          i_push,
    input  logic          i_queue_full,
    input  tfp_pkg::t_req i_req,
    output logic          o_wr,
    output tfp_pkg::t_job o_job
);

    logic w_zero;

    assign w_zero = (i_req.frequency == 16'd0);

    // Write the queue on every accepted transaction
    assign o_wr = i_push && !i_queue_full;

    always_comb begin
        o_job.divisor = w_zero ? 16'd1 : i_req.frequency;
        o_job.off     = i_req.update_pin_mode && w_zero;
        if (!i_req.update_pin_mode) begin
            o_job.pin_mode = tfp_pkg::PIN_UNCHANGED;
        end else if (w_zero) begin
            o_job.pin_mode = tfp_pkg::PIN_OFF;
        end else begin
            o_job.pin_mode = tfp_pkg::PIN_TOGGLE;
        end
    end

endmodule

/* design/tfp_queue.sv */
// ----------------------------------------------------------------------------
// tfp_queue
// Small job queue that decouples the front from the divider pipeline.
// ----------------------------------------------------------------------------
module tfp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  tfp_pkg::t_job i_job,
    input  logic          i_rd,
    output logic          o_full,
    output logic          o_vld,
    output tfp_pkg::t_job o_job
);

    localparam int unsigned PW = $clog2(tfp_pkg::QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(tfp_pkg::QUEUE_DEPTH + 1);

    tfp_pkg::t_job r_mem [tfp_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_wr, w_rd;

    assign o_full = (r_count == CW'(tfp_pkg::QUEUE_DEPTH));
    assign o_vld  = (r_count != '0);
    assign o_job  = r_mem[r_rd_ptr];

    assign w_wr = i_wr && !o_full;
    assign w_rd = i_rd && o_vld;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(tfp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(tfp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* design/tfp_back.sv */
// ----------------------------------------------------------------------------
// tfp_back
// Pipelined restoring divider of CLOCK_HZ/2 by the frequency, one quotient
// bit per stage, followed by prescaler selection into the result register.
// ----------------------------------------------------------------------------
module tfp_back #(
    parameter int unsigned CLOCK_HZ = tfp_pkg::CLOCK_HZ_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_vld,
    input  tfp_pkg::t_job    i_job,
    output logic             o_job_take,
    input  logic             i_pop,
    output logic             o_result_vld,
    output tfp_pkg::t_result o_result
);

    localparam int unsigned HALF_HZ = CLOCK_HZ / 2;
    localparam int unsigned QW      = $clog2(HALF_HZ + 1);
    localparam logic [QW-1:0] DIVIDEND = QW'(HALF_HZ);

    logic            r_vld  [QW];
    logic [15:0]     r_rem  [QW];
    logic [QW-1:0]   r_quo  [QW];
    logic [15:0]     r_div  [QW];
    logic [1:0]      r_pin  [QW];
    logic            r_off  [QW];

    logic [15:0]     w_src_rem [QW];
    logic [QW-1:0]   w_src_quo [QW];
    logic [15:0]     w_src_div [QW];
    logic [16:0]     w_trial   [QW];
    logic            w_ge      [QW];
    logic [15:0]     n_rem     [QW];
    logic [QW-1:0]   n_quo     [QW];

    logic             r_out_vld;
    tfp_pkg::t_result r_out, n_out;
    logic             w_adv;

    // Whole pipeline moves unless a finished result is stalled
    assign w_adv      = !r_out_vld || i_pop;
    assign o_job_take = w_adv && i_job_vld;

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                w_src_rem[k] = '0;
                w_src_quo[k] = '0;
                w_src_div[k] = i_job.divisor;
            end else begin
                w_src_rem[k] = r_rem[k-1];
                w_src_quo[k] = r_quo[k-1];
                w_src_div[k] = r_div[k-1];
            end
            w_trial[k] = {w_src_rem[k], DIVIDEND[QW-1-k]};
            w_ge[k]    = (w_trial[k] >= {1'b0, w_src_div[k]});
            n_rem[k]   = w_ge[k] ? 16'(w_trial[k] - {1'b0, w_src_div[k]})
                                 : w_trial[k][15:0];
            n_quo[k]   = {w_src_quo[k][QW-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_job_vld;
            for (int k = 1; k < QW; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_vld <= r_vld[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
            r_div[0] <= i_job.divisor;
            r_pin[0] <= i_job.pin_mode;
            r_off[0] <= i_job.off;
            for (int k = 1; k < QW; k++) begin
                r_div[k] <= r_div[k-1];
                r_pin[k] <= r_pin[k-1];
                r_off[k] <= r_off[k-1];
            end
            r_out <= n_out;
        end
    end

    // Pick the smallest prescaler whose range holds the tick count
    always_comb begin
        logic [QW-1:0] shifted;
        n_out.fit_found     = 1'b0;
        n_out.clock_select  = 3'd0;
        n_out.compare_value = 8'd0;
        n_out.pin_mode      = r_pin[QW-1];
        shifted             = '0;
        if (!r_off[QW-1]) begin
            for (int i = tfp_pkg::PRESC_COUNT - 1; i >= 0; i--) begin
                if (32'(r_quo[QW-1]) < tfp_pkg::presc_limit(3'(i))) begin
                    shifted             = r_quo[QW-1] >> tfp_pkg::presc_shift(3'(i));
                    n_out.fit_found     = 1'b1;
                    n_out.clock_select  = 3'(i + 1);
                    n_out.compare_value = shifted[7:0] - 8'd1;
                end
            end
        end
    end

    assign o_result_vld = r_out_vld;
    assign o_result     = r_out;

endmodule

/* design/timer_frequency_to_prescaler_core.sv */
// ----------------------------------------------------------------------------
// timer_frequency_to_prescaler_core
// Turns a wanted toggle frequency into a timer clock-select code, an 8-bit
// compare value and an output pin mode.
// ----------------------------------------------------------------------------
// The core takes one request per clock while the job queue is not full, and
// returns one result per request, in order. On the way from an accepted push
// to the result, the job queue is written when the push is accepted and
// hands the job to the first divider stage when the pipeline advances, then
// there is one divider stage per quotient bit of CLOCK_HZ/2 / frequency,
// QW = clog2(CLOCK_HZ/2 + 1) stages in all, and prescaler selection into the
// result register. Throughput is set by the divider pipeline, which takes a
// new job every cycle while the result side keeps popping; while a result
// waits, the pipeline holds and the job queue in front of it keeps absorbing
// requests until it fills.
// ----------------------------------------------------------------------------
module timer_frequency_to_prescaler_core #(
    parameter int unsigned CLOCK_HZ = tfp_pkg::CLOCK_HZ_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Request side: a transaction completes when push is high and full low
    input  logic             push,
    output logic             full,
    input  tfp_pkg::t_req    i_data,
    // Result side: a transaction completes when pop is high and empty low
    output logic             empty,
    input  logic             pop,
    output tfp_pkg::t_result o_data
);

    tfp_pkg::t_job w_front_job;
    tfp_pkg::t_job w_queue_job;
    logic          w_front_wr;
    logic          w_queue_full;
    logic          w_queue_vld;
    logic          w_back_take;
    logic          w_result_vld;

    // Classify each request: fold zero frequency to one, flag off requests
    tfp_front u_front (
        .i_push       (push),
        .i_queue_full (w_queue_full),
        .i_req        (i_data),
        .o_wr         (w_front_wr),
        .o_job        (w_front_job)
    );

    // Hold classified jobs so the front keeps accepting while the back stalls
    tfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_front_wr),
        .i_job   (w_front_job),
        .i_rd    (w_back_take),
        .o_full  (w_queue_full),
        .o_vld   (w_queue_vld),
        .o_job   (w_queue_job)
    );

    // Divide, select the prescaler and hold the result until popped
    tfp_back #(
        .CLOCK_HZ (CLOCK_HZ)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_vld    (w_queue_vld),
        .i_job        (w_queue_job),
        .o_job_take   (w_back_take),
        .i_pop        (pop),
        .o_result_vld (w_result_vld),
        .o_result     (o_data)
    );

    assign full  = w_queue_full;
    assign empty = !w_result_vld;

endmodule
